>>> hw/rtl/pcts_pkg.sv
`default_nettype none

package pcts_pkg;

    localparam int unsigned PIXEL_W = 24;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned CHANS   = 3;
    localparam int unsigned COORD_W = 15;
    localparam int unsigned RES_W   = 16;
    localparam int unsigned RWID_W  = 13;
    localparam int unsigned TOL_W   = 8;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_TARGET_COLOR    = 3'd0;
    localparam cfg_idx_t REG_MATCH_TOLERANCE = 3'd1;
    localparam cfg_idx_t REG_MASK_LOW_BITS   = 3'd2;
    localparam cfg_idx_t REG_ORIGIN_X        = 3'd3;
    localparam cfg_idx_t REG_ORIGIN_Y        = 3'd4;
    localparam cfg_idx_t REG_REGION_WIDTH    = 3'd5;

    localparam logic [PIXEL_W-1:0] RST_TARGET_COLOR = 24'hFF_FFFF;
    localparam logic [RWID_W-1:0]  RST_REGION_WIDTH = 13'd1920;

    localparam logic [CHAN_W-1:0] CHAN_MASK_16BPP = 8'hF8;
    localparam logic [CHAN_W-1:0] CHAN_MAX        = 8'hFF;

    // Inclusive window around target, clamped to the channel range.
    function automatic logic channel_ok(
        input logic [CHAN_W-1:0] pix,
        input logic [CHAN_W-1:0] tgt,
        input logic [TOL_W-1:0]  tol
    );
        logic [CHAN_W:0]   hi_sum;
        logic [CHAN_W-1:0] lo;
        logic [CHAN_W-1:0] hi;
        hi_sum = {1'b0, tgt} + {1'b0, tol};
        lo     = (tol > tgt) ? '0 : (tgt - tol);
        hi     = hi_sum[CHAN_W] ? CHAN_MAX : hi_sum[CHAN_W-1:0];
        return (pix >= lo) && (pix <= hi);
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pixel_color_tolerance_search_unit.sv
`default_nettype none

// Color-key search over a raster-order pixel stream. Every pixel is checked
// against target_color within +/- match_tolerance per channel (optionally on
// 5-bit channels), column/row are tracked from region_width, and the first
// hit of the frame is latched. The pixel flagged frame_last produces one
// result word: match_found and the screen position origin + (column, row),
// or -1,-1 when nothing matched. One pixel is taken every cycle while
// in_stall is low; a word enters an input register, then compare and
// counter update sit between it and the state/result registers. Only a
// frame_last word can be held there, and only while the result register
// is full and stalled, with in_stall high. The configuration port never stalls.
module pixel_color_tolerance_search_unit #(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pcts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pcts_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [pcts_pkg::PIXEL_W-1:0]        pixel_value,
    input  wire logic                                frame_last,

    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     match_found,
    output logic signed [pcts_pkg::RES_W-1:0]        match_x,
    output logic signed [pcts_pkg::RES_W-1:0]        match_y
);

    localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);
    localparam int unsigned WEFF_W = $clog2(MAX_WIDTH + 1);
    localparam int unsigned CMP_W  =
        ((WEFF_W > pcts_pkg::RWID_W) ? WEFF_W : pcts_pkg::RWID_W) + 1;
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_HEIGHT - 1);
    localparam logic [CMP_W-1:0] WIDTH_MAX = CMP_W'(MAX_WIDTH);

    // Configuration registers
    logic [pcts_pkg::PIXEL_W-1:0] target_reg;
    logic [pcts_pkg::TOL_W-1:0]   tol_reg;
    logic                         mask_reg;
    logic [pcts_pkg::COORD_W-1:0] origin_x_reg;
    logic [pcts_pkg::COORD_W-1:0] origin_y_reg;
    logic [pcts_pkg::RWID_W-1:0]  width_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= pcts_pkg::RST_TARGET_COLOR;
            tol_reg      <= '0;
            mask_reg     <= 1'b0;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            width_reg    <= pcts_pkg::RST_REGION_WIDTH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pcts_pkg::REG_TARGET_COLOR:    target_reg   <= cfg_data;
                pcts_pkg::REG_MATCH_TOLERANCE: tol_reg      <= cfg_data[pcts_pkg::TOL_W-1:0];
                pcts_pkg::REG_MASK_LOW_BITS:   mask_reg     <= cfg_data[0];
                pcts_pkg::REG_ORIGIN_X:        origin_x_reg <= cfg_data[pcts_pkg::COORD_W-1:0];
                pcts_pkg::REG_ORIGIN_Y:        origin_y_reg <= cfg_data[pcts_pkg::COORD_W-1:0];
                pcts_pkg::REG_REGION_WIDTH:    width_reg    <= cfg_data[pcts_pkg::RWID_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    logic                         s1_valid_reg;
    logic [pcts_pkg::PIXEL_W-1:0] s1_pixel_reg;
    logic                         s1_last_reg;

    logic out_free;
    logic s1_retire;
    logic in_take;

    assign out_free  = !out_valid || !out_stall;
    // Only a last word needs room in the result register.
    assign s1_retire = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall  = s1_valid_reg && !s1_retire;
    assign in_take   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_retire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_pixel_reg <= pixel_value;
            s1_last_reg  <= frame_last;
        end
    end

    // Color compare
    logic [pcts_pkg::PIXEL_W-1:0] pix_m;
    logic [pcts_pkg::PIXEL_W-1:0] tgt_m;
    logic [pcts_pkg::CHANS-1:0]   chan_hit;
    logic                         pix_hit;

    always_comb
    begin
        pix_m = s1_pixel_reg;
        tgt_m = target_reg;
        if (mask_reg)
        begin
            pix_m = pix_m & {pcts_pkg::CHANS{pcts_pkg::CHAN_MASK_16BPP}};
            tgt_m = tgt_m & {pcts_pkg::CHANS{pcts_pkg::CHAN_MASK_16BPP}};
        end
        for (int c = 0; c < pcts_pkg::CHANS; c++)
        begin
            chan_hit[c] = pcts_pkg::channel_ok(
                pix_m[c*pcts_pkg::CHAN_W +: pcts_pkg::CHAN_W],
                tgt_m[c*pcts_pkg::CHAN_W +: pcts_pkg::CHAN_W],
                tol_reg);
        end
        pix_hit = &chan_hit;
    end

    // Position tracking
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             seen_reg, seen_next;
    logic [COL_W-1:0] hit_col_reg, hit_col_next;
    logic [ROW_W-1:0] hit_row_reg, hit_row_next;

    logic [CMP_W-1:0] width_ext;
    logic [CMP_W-1:0] width_eff;
    logic [CMP_W-1:0] col_inc;
    logic             take_hit;

    always_comb
    begin
        width_ext = CMP_W'(width_reg);
        if (width_ext == '0)
            width_eff = CMP_W'(1);
        else if (width_ext > WIDTH_MAX)
            width_eff = WIDTH_MAX;
        else
            width_eff = width_ext;
        col_inc  = CMP_W'(col_reg) + CMP_W'(1);
        take_hit = !seen_reg && pix_hit;

        hit_col_next = take_hit ? col_reg : hit_col_reg;
        hit_row_next = take_hit ? row_reg : hit_row_reg;
        seen_next    = seen_reg || pix_hit;
        col_next     = col_reg;
        row_next     = row_reg;

        if (s1_last_reg)
        begin
            col_next  = '0;
            row_next  = '0;
            seen_next = 1'b0;
        end
        else if (col_inc >= width_eff)
        begin
            col_next = '0;
            if (row_reg != ROW_LAST)
                row_next = row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            seen_reg    <= 1'b0;
            hit_col_reg <= '0;
            hit_row_reg <= '0;
        end
        else if (s1_retire)
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            seen_reg    <= seen_next;
            hit_col_reg <= hit_col_next;
            hit_row_reg <= hit_row_next;
        end
    end

    // Result register
    logic [pcts_pkg::RES_W-1:0] x_sum;
    logic [pcts_pkg::RES_W-1:0] y_sum;
    logic                       found;

    always_comb
    begin
        found = seen_reg || pix_hit;
        x_sum = {origin_x_reg[pcts_pkg::COORD_W-1], origin_x_reg}
              + pcts_pkg::RES_W'(hit_col_next);
        y_sum = {origin_y_reg[pcts_pkg::COORD_W-1], origin_y_reg}
              + pcts_pkg::RES_W'(hit_row_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (s1_retire && s1_last_reg)
        begin
            out_valid <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_retire && s1_last_reg)
        begin
            match_found <= found;
            match_x     <= found ? x_sum : '1;
            match_y     <= found ? y_sum : '1;
        end
    end

endmodule

`default_nettype wire
